// ===== rtl/core/unit_cross_product_defines.svh =====
// assertion macros shared by the rtl
`ifndef UNIT_CROSS_PRODUCT_DEFINES_SVH
`define UNIT_CROSS_PRODUCT_DEFINES_SVH
`ifndef SYNTHESIS
`define UCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ucp assertion failed");
`define UCP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ucp forbidden condition seen");
`else
`define UCP_ASSERT(lbl, prop)
`define UCP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/ucp_pkg.sv =====
`default_nettype none
package ucp_pkg;

  // operand and result widths
  localparam int IN_W     = 16;
  localparam int OUT_FRAC = 14;
  localparam int OUT_W    = OUT_FRAC + 2;

  // internal exact widths
  localparam int MAG_W  = 2 * IN_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RAD_W  = SUM_W + 2 * OUT_FRAC;
  localparam int ROOT_W = RAD_W / 2;
  localparam int QUO_W  = OUT_FRAC + 2;
  localparam int DNUM_W = ROOT_W + QUO_W;

  // lane stages, sum stage, root stages, divide stages, output stage
  localparam int LAT = 3 + 1 + ROOT_W + QUO_W + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] b_z;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] n_x;
    logic signed [OUT_W-1:0] n_y;
    logic signed [OUT_W-1:0] n_z;
    logic                    degenerate;
  } out_word_t;

  // per-item info carried alongside the root pipeline
  typedef struct packed {
    logic                  deg;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/ucp_lane.sv =====
`default_nettype none
module ucp_lane import ucp_pkg::*; (
  input  logic                   clk,
  input  logic signed [IN_W-1:0] p,
  input  logic signed [IN_W-1:0] q,
  input  logic signed [IN_W-1:0] r,
  input  logic signed [IN_W-1:0] s,
  output logic [MAG_W-1:0]       mag,
  output logic                   neg,
  output logic [SQ_W-1:0]        sq
);

  localparam int C_W = 2 * IN_W + 1;

  logic signed [2*IN_W-1:0] ps_r, qr_r;
  logic signed [C_W-1:0]    c_r, c_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic                     neg_r;
  logic [SQ_W-1:0]          sq_r;

  // component is p*s - q*r, exact
  assign c_nxt   = C_W'(ps_r) - C_W'(qr_r);
  assign mag_nxt = c_r[C_W-1] ? MAG_W'(-c_r) : MAG_W'(c_r);

  // products, difference, magnitude and square
  always_ff @(posedge clk) begin
    ps_r  <= p * s;
    qr_r  <= q * r;
    c_r   <= c_nxt;
    neg_r <= c_r[C_W-1];
    mag_r <= mag_nxt;
    sq_r  <= SQ_W'(mag_nxt) * SQ_W'(mag_nxt);
  end

  assign mag = mag_r;
  assign neg = neg_r;
  assign sq  = sq_r;

endmodule
`default_nettype wire

// ===== rtl/core/ucp_isqrt.sv =====
`default_nettype none
module ucp_isqrt #(
  parameter int ROOT_W = 47,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   rad,
  input  logic [SIDE_W-1:0]     side_in,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int N_W = 2 * ROOT_W;

  logic [N_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  // one root bit per stage, msb first, remainder kept exact
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [N_W-1:0]    rem_in, trial, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;
    logic [SIDE_W-1:0] side_i;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
      assign side_i  = side_in;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_i  = side_r[i-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial    = (N_W'(root_in) << (K + 1)) + (N_W'(1) << (2 * K));
    assign ge       = (rem_in >= trial);
    assign rem_nxt  = ge ? (rem_in - trial) : rem_in;
    assign root_nxt = root_in | (ROOT_W'(ge) << K);

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      side_r[i] <= side_i;
    end
  end

  assign root     = root_r[ROOT_W-1];
  assign side_out = side_r[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/ucp_div.sv =====
`default_nettype none
module ucp_div #(
  parameter int DEN_W  = 47,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic [DEN_W+Q_W-1:0]    num,
  input  logic [DEN_W-1:0]        den,
  input  logic [SIDE_W-1:0]       side_in,
  output logic [Q_W-1:0]          quo,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int R_W = DEN_W + Q_W;

  logic [R_W-1:0]    rem_r  [Q_W];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [Q_W-1:0]    quo_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  // restoring division, one quotient bit per stage, msb first
  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic [R_W-1:0]    rem_in, trial, rem_nxt;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quo_in, quo_nxt;
    logic [SIDE_W-1:0] side_i;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign trial   = R_W'(den_in) << K;
    assign ge      = (rem_in >= trial);
    assign rem_nxt = ge ? (rem_in - trial) : rem_in;
    assign quo_nxt = quo_in | (Q_W'(ge) << K);

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      den_r[i]  <= den_in;
      quo_r[i]  <= quo_nxt;
      side_r[i] <= side_i;
    end
  end

  assign quo      = quo_r[Q_W-1];
  assign side_out = side_r[Q_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/unit_cross_product.sv =====
// channel  ports                          direction  handshake
// input    start, busy, in_word           in         taken when start && !busy
// result   out_valid, out_word            out        one-cycle strobe, no stall
//
// fully pipelined: one word per cycle, busy is always low
// the data passes in order through the lane stages, the sum stage, the bit-per-stage square root,
//   the three parallel bit-per-stage dividers and the output stage
// synchronous active-low reset clears the valid line only
// results cannot be held off: each one is shown for exactly one cycle
`default_nettype none
`include "unit_cross_product_defines.svh"
module unit_cross_product import ucp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  logic [2:0][MAG_W-1:0] mag;
  logic [2:0]            neg;
  logic [2:0][SQ_W-1:0]  sq;

  // x lane: a_y*b_z - b_y*a_z
  ucp_lane u_lane_x (
    .clk(clk), .p(in_word.a_y), .q(in_word.b_y), .r(in_word.a_z), .s(in_word.b_z),
    .mag(mag[0]), .neg(neg[0]), .sq(sq[0])
  );
  // y lane: b_x*a_z - a_x*b_z
  ucp_lane u_lane_y (
    .clk(clk), .p(in_word.b_x), .q(in_word.a_x), .r(in_word.b_z), .s(in_word.a_z),
    .mag(mag[1]), .neg(neg[1]), .sq(sq[1])
  );
  // z lane: a_x*b_y - b_x*a_y
  ucp_lane u_lane_z (
    .clk(clk), .p(in_word.a_x), .q(in_word.b_x), .r(in_word.a_y), .s(in_word.b_y),
    .mag(mag[2]), .neg(neg[2]), .sq(sq[2])
  );

  // merge: squared length and item info
  logic [SUM_W-1:0] sum_r, sum_nxt;
  side_t            side_r, side_nxt;

  always_comb begin
    sum_nxt      = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    side_nxt.mag = mag;
    side_nxt.neg = neg;
    side_nxt.deg = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    side_r <= side_nxt;
  end

  // root of the scaled squared length
  logic [ROOT_W-1:0] root;
  side_t             side_q;

  ucp_isqrt #(.ROOT_W(ROOT_W), .SIDE_W($bits(side_t))) u_isqrt (
    .clk(clk),
    .rad({sum_r, {(2*OUT_FRAC){1'b0}}}),
    .side_in(side_r),
    .root(root),
    .side_out(side_q)
  );

  // one divider per component
  logic [2:0][QUO_W-1:0] quo;
  logic [1:0]            side_x;
  logic                  neg_y, neg_z;

  ucp_div #(.DEN_W(ROOT_W), .Q_W(QUO_W), .SIDE_W(2)) u_div_x (
    .clk(clk), .num(DNUM_W'({side_q.mag[0], {(2*OUT_FRAC){1'b0}}})), .den(root),
    .side_in({side_q.deg, side_q.neg[0]}), .quo(quo[0]), .side_out(side_x)
  );
  ucp_div #(.DEN_W(ROOT_W), .Q_W(QUO_W), .SIDE_W(1)) u_div_y (
    .clk(clk), .num(DNUM_W'({side_q.mag[1], {(2*OUT_FRAC){1'b0}}})), .den(root),
    .side_in(side_q.neg[1]), .quo(quo[1]), .side_out(neg_y)
  );
  ucp_div #(.DEN_W(ROOT_W), .Q_W(QUO_W), .SIDE_W(1)) u_div_z (
    .clk(clk), .num(DNUM_W'({side_q.mag[2], {(2*OUT_FRAC){1'b0}}})), .den(root),
    .side_in(side_q.neg[2]), .quo(quo[2]), .side_out(neg_z)
  );

  // clamp, sign and degenerate override
  localparam logic [QUO_W-1:0] LIM = QUO_W'(1) << OUT_FRAC;

  logic [2:0]            sgn;
  logic [2:0][OUT_W-1:0] nval;
  out_word_t             word_r, word_nxt;

  assign sgn = {neg_z, neg_y, side_x[0]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QUO_W-1:0] qc;
      qc      = (quo[i] > LIM) ? LIM : quo[i];
      nval[i] = sgn[i] ? OUT_W'(-qc) : OUT_W'(qc);
    end
    word_nxt.degenerate = side_x[1];
    word_nxt.n_x = side_x[1] ? '0 : nval[0];
    word_nxt.n_y = side_x[1] ? '0 : nval[1];
    word_nxt.n_z = side_x[1] ? '0 : nval[2];
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // valid line follows the data pipeline
  logic [LAT-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[LAT-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];
  assign out_word  = word_r;

  // checks
  `UCP_ASSERT(a_lat_fwd, start |-> ##LAT out_valid)
  `UCP_ASSERT(a_lat_back, out_valid |-> $past(start, LAT))
  `UCP_ASSERT(a_deg_zero, out_valid && out_word.degenerate |->
    out_word.n_x == '0 && out_word.n_y == '0 && out_word.n_z == '0)
  `UCP_ASSERT_NEVER(a_nondeg_nonzero, out_valid && !out_word.degenerate &&
    out_word.n_x == '0 && out_word.n_y == '0 && out_word.n_z == '0)

endmodule
`default_nettype wire

// ===== verif/unit_cross_product_test.sv =====
`timescale 1ns / 100ps
module unit_cross_product_test;
  import ucp_pkg::*;

  // normal predictor and store of pending normals
  class normal_board;
    out_word_t pending[$];
    int errors = 0;

    function automatic logic [127:0] root_floor(logic [127:0] n);
      logic [127:0] root;
      logic [127:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function automatic out_word_t unit_normal(in_word_t w);
      out_word_t n;
      longint signed cr[3];
      logic [63:0] mag[3];
      logic [127:0] sum;
      logic [127:0] root;
      logic [127:0] q;
      logic signed [OUT_W-1:0] comp[3];
      cr[0] = longint'(w.a_y) * w.b_z - longint'(w.b_y) * w.a_z;
      cr[1] = -(longint'(w.a_x) * w.b_z - longint'(w.b_x) * w.a_z);
      cr[2] = longint'(w.a_x) * w.b_y - longint'(w.b_x) * w.a_y;
      n = '0;
      if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
        n.degenerate = 1'b1;
        return n;
      end
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
        sum += 128'(mag[i]) * 128'(mag[i]);
      end
      root = root_floor(sum << (2 * OUT_FRAC));
      for (int i = 0; i < 3; i++) begin
        q = (128'(mag[i]) << (2 * OUT_FRAC)) / root;
        if (q > (128'd1 << OUT_FRAC)) q = 128'd1 << OUT_FRAC;
        comp[i] = cr[i] < 0 ? -q[OUT_W-1:0] : q[OUT_W-1:0];
      end
      n.n_x = comp[0];
      n.n_y = comp[1];
      n.n_z = comp[2];
      return n;
    endfunction

    function void note_word(in_word_t w);
      pending.push_back(unit_normal(w));
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected normal %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.n_x !== exp_w.n_x) begin
        $error("n_x exp %0d got %0d", exp_w.n_x, got.n_x); errors++;
      end
      if (got.n_y !== exp_w.n_y) begin
        $error("n_y exp %0d got %0d", exp_w.n_y, got.n_y); errors++;
      end
      if (got.n_z !== exp_w.n_z) begin
        $error("n_z exp %0d got %0d", exp_w.n_z, got.n_z); errors++;
      end
      if (got.degenerate !== exp_w.degenerate) begin
        $error("degenerate exp %0b got %0b", exp_w.degenerate, got.degenerate); errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  int        cycles = 0;
  normal_board board = new();

  unit_cross_product DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted words and results, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_word(in_word);
    if (rst_n && out_valid) board.check_word(out_word);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("unit_cross_product test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one word, holding start across back-to-back words
  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_word(int ax, int ay, int az, int bx, int by, int bz);
    in_word_t w;
    w.a_x = ax; w.a_y = ay; w.a_z = az;
    w.b_x = bx; w.b_y = by; w.b_z = bz;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int k;
    int mode;
    mode = $urandom_range(0, 9);
    w = {$urandom, $urandom, $urandom};
    if (mode < 2) begin
      // small components
      w = make_word($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
        $urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
        $urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8);
    end else if (mode == 2) begin
      // parallel vectors, zero cross product
      k = $urandom_range(0, 6) - 3;
      w = make_word($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
        $urandom_range(0, 8000) - 4000, 0, 0, 0);
      w.b_x = w.a_x * k; w.b_y = w.a_y * k; w.b_z = w.a_z * k;
    end else if (mode == 3) begin
      // components at the range ends
      for (int i = 0; i < 6; i++)
        w[i*IN_W +: IN_W] = ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
    end
    return w;
  endfunction

  initial begin
    in_word_t dir[$];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, parallel, axis, extreme and mixed vectors
    dir.push_back(make_word(0, 0, 0, 0, 0, 0));
    dir.push_back(make_word(1, 2, 3, 2, 4, 6));
    dir.push_back(make_word(1, 0, 0, 0, 1, 0));
    dir.push_back(make_word(0, 1, 0, 0, 0, 1));
    dir.push_back(make_word(0, 0, 1, 1, 0, 0));
    dir.push_back(make_word(0, 1, 0, 1, 0, 0));
    dir.push_back(make_word(-32768, 0, 0, 0, -32768, 0));
    dir.push_back(make_word(32767, 32767, 32767, -32768, -32768, 32767));
    dir.push_back(make_word(-32768, -32768, -32768, -32768, -32768, -32768));
    dir.push_back(make_word(-32768, 32767, -32768, 32767, -32768, 32767));
    dir.push_back(make_word(32767, -32768, 0, -32768, 32767, 0));
    dir.push_back(make_word(1, 1, 0, 1, -1, 0));
    dir.push_back(make_word(3, 0, 0, 0, 4, 0));
    dir.push_back(make_word(1, 1, 1, -1, 1, 1));
    dir.push_back(make_word(32767, 1, 0, 32766, 1, 0));
    dir.push_back(make_word(-1, -1, -1, 1, 1, 1));
    dir.push_back(make_word(12345, -23456, 31000, -7, 9, 32767));
    foreach (dir[i]) send_word(dir[i], i % 3 == 0 ? 0 : pick_gap());
    drain();

    for (int n = 0; n < 900; n++) begin
      if (n == 450) drain();
      if (n >= 600 && n < 700) send_word(random_word(), 0);
      else send_word(random_word(), pick_gap());
    end
    drain();
    repeat (LAT + 20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("unit_cross_product test passed");
    else
      $display("unit_cross_product test failed");
    $finish;
  end
endmodule
